// ===== rtl/jpeg_block_quantizer_top_defines.svh =====
// assertion macros for the block quantizer checker
`ifndef JPEG_BLOCK_QUANTIZER_TOP_DEFINES_SVH
`define JPEG_BLOCK_QUANTIZER_TOP_DEFINES_SVH

// property checked only outside reset
`define JBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define JBQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/jbq_pkg.sv =====
// shared types, constants and helpers of the block quantizer
package jbq_pkg;

  localparam int BLOCK_COEFFS = 64;
  localparam int POS_W        = $clog2(BLOCK_COEFFS);
  localparam int COEF_W       = 16;
  localparam int ENTRY_W      = 8;
  localparam int QUAL_W       = 7;
  localparam int OUT_W        = 8;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

  // quality scale
  localparam int QUALITY_RESET = 50;
  localparam int QUALITY_MIN   = 1;
  localparam int QUALITY_MAX   = 100;
  localparam int QUALITY_KNEE  = 50;
  localparam int SCALE_NUM     = 5000;
  localparam int SCALE_OFFSET  = 200;
  localparam int SCALE_W       = $clog2(SCALE_NUM + 1);

  // scaled entry: (scale * entry + ROUND_BIAS) / SCALE_DENOM
  localparam int ROUND_BIAS   = 50;
  localparam int SCALE_DENOM  = 100;
  localparam int PROD_W       = SCALE_W + ENTRY_W;
  localparam int PRE_SHIFT    = 2;
  localparam int POST_DIV     = SCALE_DENOM >> PRE_SHIFT;
  localparam int Y_W          = PROD_W - PRE_SHIFT;
  localparam int RECIP_SHIFT  = 18;
  localparam int RECIP_M      = (1 << RECIP_SHIFT) / POST_DIV;
  localparam int RECIP_W      = $clog2(RECIP_M + 1);
  localparam int EST_W        = Y_W + RECIP_W;
  localparam int EST_Q_W      = EST_W - RECIP_SHIFT;
  localparam int DEN_W        = 14;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUANT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_MUL,
    BK_RECIP,
    BK_CORR,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [ENTRY_W-1:0]       entry;
    logic [POS_W-1:0]         pos;
  } q_entry_t;

  function automatic logic [QUAL_W-1:0] qual_clamp(input logic [QUAL_W-1:0] q);
    logic [QUAL_W-1:0] r;
    r = q;
    if (q < QUAL_W'(QUALITY_MIN)) r = QUAL_W'(QUALITY_MIN);
    if (q > QUAL_W'(QUALITY_MAX)) r = QUAL_W'(QUALITY_MAX);
    return r;
  endfunction

endpackage

// ===== rtl/jbq_ram.sv =====
// generic single-write, single-read ram with registered read data
module jbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/jbq_front.sv =====
// front end: takes items, loads the table, tags coefficients and queues them
module jbq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [jbq_pkg::POS_W-1:0]         table_index,
  input  logic [jbq_pkg::ENTRY_W-1:0]       table_value,
  input  logic signed [jbq_pkg::COEF_W-1:0] coefficient,
  input  logic                              q_full,
  output logic                              q_push,
  output jbq_pkg::q_entry_t                 q_data
);

  logic                              accept;
  logic                              take_load;
  logic                              take_quant;
  logic [jbq_pkg::POS_W-1:0]         pos_cnt;
  logic                              stage_valid;
  logic signed [jbq_pkg::COEF_W-1:0] stage_coef;
  logic [jbq_pkg::POS_W-1:0]         stage_pos;
  logic [jbq_pkg::ENTRY_W-1:0]       entry_rd;

  // the stage drains into the queue; a new item comes in once it can leave
  assign in_ready   = !stage_valid || !q_full;
  assign accept     = in_valid && in_ready;
  assign take_load  = accept && (command == jbq_pkg::CMD_LOAD);
  assign take_quant = accept && (command == jbq_pkg::CMD_QUANT);
  assign q_push     = stage_valid && !q_full;

  // table is read when the coefficient is taken, so later loads cannot reach it
  jbq_ram #(
    .WIDTH (jbq_pkg::ENTRY_W),
    .DEPTH (jbq_pkg::BLOCK_COEFFS)
  ) u_table (
    .clk   (clk),
    .we    (take_load),
    .waddr (table_index),
    .wdata (table_value),
    .re    (take_quant),
    .raddr (pos_cnt),
    .rdata (entry_rd)
  );

  always_comb begin
    q_data.coef  = stage_coef;
    q_data.entry = entry_rd;
    q_data.pos   = stage_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      pos_cnt     <= '0;
    end else begin
      if (take_quant) begin
        stage_valid <= 1'b1;
        pos_cnt     <= (pos_cnt == jbq_pkg::LAST_POS) ? '0 : pos_cnt + 1'b1;
      end else if (q_push) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_quant) begin
      stage_coef <= coefficient;
      stage_pos  <= pos_cnt;
    end
  end

endmodule

// ===== rtl/jbq_fifo.sv =====
// short queue of tagged coefficients between front and back
module jbq_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jbq_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output jbq_pkg::q_entry_t pop_data,
  output logic              empty
);

  jbq_pkg::q_entry_t            slots [jbq_pkg::QUEUE_DEPTH];
  logic [jbq_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [jbq_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [jbq_pkg::QUEUE_AW:0]   count;

  localparam logic [jbq_pkg::QUEUE_AW-1:0] PTR_LAST =
    jbq_pkg::QUEUE_AW'(jbq_pkg::QUEUE_DEPTH - 1);

  assign full     = (count == (jbq_pkg::QUEUE_AW + 1)'(jbq_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/jbq_back.sv =====
// back end: scales the table entry, divides the coefficient, saturates the result
module jbq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [jbq_pkg::QUAL_W-1:0]        cfg_data,
  input  logic                              q_empty,
  input  jbq_pkg::q_entry_t                 q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [jbq_pkg::OUT_W-1:0]  quantized,
  output logic [jbq_pkg::POS_W-1:0]         position,
  output logic                              last_in_block
);

  localparam int DIV_N = jbq_pkg::COEF_W;
  localparam int CNT_W = $clog2(DIV_N);
  localparam int DEN_W = jbq_pkg::DEN_W;

  jbq_pkg::back_state_t state, state_next;

  logic [jbq_pkg::QUAL_W-1:0]  quality;
  logic [jbq_pkg::QUAL_W-1:0]  qc;
  logic [jbq_pkg::QUAL_W-1:0]  scale_q;
  logic                        scale_ok;
  logic                        scale_fresh;
  logic                        low_q;
  logic [jbq_pkg::SCALE_W-1:0] scale;
  logic [jbq_pkg::SCALE_W-1:0] scale_hi;

  jbq_pkg::q_entry_t           work;
  logic [jbq_pkg::PROD_W-1:0]  prod;
  logic [jbq_pkg::PROD_W-1:0]  prod_biased;
  logic [jbq_pkg::Y_W-1:0]     y;
  logic [jbq_pkg::EST_W-1:0]   est;
  logic [jbq_pkg::EST_Q_W-1:0] q0;
  logic [jbq_pkg::Y_W-1:0]     q0_x;
  logic [jbq_pkg::Y_W-1:0]     rr;
  logic [jbq_pkg::EST_Q_W-1:0] q1;
  logic [DEN_W-1:0]            den_new;

  logic [DEN_W-1:0]            rem;
  logic [DIV_N-1:0]            quo;
  logic [DEN_W-1:0]            den;
  logic [CNT_W-1:0]            cnt;
  logic [DEN_W:0]              trial;
  logic [DEN_W:0]              diff;
  logic                        fits;
  logic [DEN_W-1:0]            rem_step;
  logic [DIV_N-1:0]            quo_step;
  logic [DIV_N-1:0]            coef_mag;

  logic                        [jbq_pkg::OUT_W-1:0] sat;

  // control outputs
  logic scale_direct;
  logic scale_start;
  logic scale_done;
  logic div_step;
  logic div_start;
  logic out_load;

  assign qc          = jbq_pkg::qual_clamp(quality);
  assign scale_fresh = scale_ok && (scale_q == quality);
  assign low_q       = (qc < jbq_pkg::QUAL_W'(jbq_pkg::QUALITY_KNEE));
  assign scale_hi    = jbq_pkg::SCALE_W'(jbq_pkg::SCALE_OFFSET) -
                       {{(jbq_pkg::SCALE_W - jbq_pkg::QUAL_W - 1){1'b0}}, qc, 1'b0};

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quo[DIV_N-1]};
  assign diff     = trial - {1'b0, den};
  assign fits     = (trial >= {1'b0, den});
  assign rem_step = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quo_step = {quo[DIV_N-2:0], fits};

  assign coef_mag = work.coef[jbq_pkg::COEF_W-1] ? (~work.coef + 1'b1) : work.coef;

  // divide by the table denominator: drop two bits, then reciprocal of 25
  assign prod_biased = prod + jbq_pkg::PROD_W'(jbq_pkg::ROUND_BIAS);
  assign q0          = est[jbq_pkg::EST_W-1:jbq_pkg::RECIP_SHIFT];
  assign q0_x        = jbq_pkg::Y_W'(q0) * jbq_pkg::Y_W'(jbq_pkg::POST_DIV);
  assign rr          = y - q0_x;
  assign q1          = (rr >= jbq_pkg::Y_W'(jbq_pkg::POST_DIV)) ? q0 + 1'b1 : q0;
  // zero divisor is forced to one
  assign den_new     = (q1 == '0) ? DEN_W'(1) : q1[DEN_W-1:0];

  // signed saturation of the quotient magnitude
  always_comb begin
    if (work.coef[jbq_pkg::COEF_W-1]) begin
      if (quo > DIV_N'(128)) begin
        sat = 8'h80;
      end else begin
        sat = ~quo[jbq_pkg::OUT_W-1:0] + 1'b1;
      end
    end else begin
      if (quo > DIV_N'(127)) begin
        sat = 8'h7f;
      end else begin
        sat = quo[jbq_pkg::OUT_W-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jbq_pkg::BK_IDLE: begin
        if (!scale_fresh) begin
          state_next = low_q ? jbq_pkg::BK_SCALE : jbq_pkg::BK_IDLE;
        end else if (!q_empty) begin
          state_next = jbq_pkg::BK_MUL;
        end
      end
      jbq_pkg::BK_SCALE: begin
        if (cnt == '0) state_next = jbq_pkg::BK_IDLE;
      end
      jbq_pkg::BK_MUL:   state_next = jbq_pkg::BK_RECIP;
      jbq_pkg::BK_RECIP: state_next = jbq_pkg::BK_CORR;
      jbq_pkg::BK_CORR:  state_next = jbq_pkg::BK_DIV;
      jbq_pkg::BK_DIV: begin
        if (cnt == '0) state_next = jbq_pkg::BK_DONE;
      end
      jbq_pkg::BK_DONE: begin
        if (!out_valid || out_ready) state_next = jbq_pkg::BK_IDLE;
      end
      default: state_next = jbq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    scale_direct = 1'b0;
    scale_start  = 1'b0;
    scale_done   = 1'b0;
    q_pop        = 1'b0;
    div_step     = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      jbq_pkg::BK_IDLE: begin
        scale_direct = !scale_fresh && !low_q;
        scale_start  = !scale_fresh && low_q;
        q_pop        = scale_fresh && !q_empty;
      end
      jbq_pkg::BK_SCALE: begin
        div_step   = 1'b1;
        scale_done = (cnt == '0);
      end
      jbq_pkg::BK_CORR:  div_start = 1'b1;
      jbq_pkg::BK_DIV:   div_step  = 1'b1;
      jbq_pkg::BK_DONE:  out_load  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jbq_pkg::BK_IDLE;
      quality   <= jbq_pkg::QUAL_W'(jbq_pkg::QUALITY_RESET);
      scale_ok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        quality <= cfg_data;
      end
      if (scale_direct || scale_done) begin
        scale_ok <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scale_direct) begin
      scale   <= scale_hi;
      scale_q <= quality;
    end
    // tag the scale with the quality the divider starts from
    if (scale_start) begin
      scale_q <= quality;
    end
    if (scale_done) begin
      scale <= quo_step[jbq_pkg::SCALE_W-1:0];
    end
    if (q_pop) begin
      work <= q_data;
    end
    if (state == jbq_pkg::BK_MUL) begin
      prod <= scale * work.entry;
    end
    if (state == jbq_pkg::BK_RECIP) begin
      y   <= prod_biased[jbq_pkg::PROD_W-1:jbq_pkg::PRE_SHIFT];
      est <= prod_biased[jbq_pkg::PROD_W-1:jbq_pkg::PRE_SHIFT] *
             jbq_pkg::RECIP_W'(jbq_pkg::RECIP_M);
    end
    if (scale_start) begin
      rem <= '0;
      quo <= DIV_N'(jbq_pkg::SCALE_NUM);
      den <= DEN_W'(qc);
      cnt <= CNT_W'(DIV_N - 1);
    end else if (div_start) begin
      rem <= '0;
      quo <= coef_mag;
      den <= den_new;
      cnt <= CNT_W'(DIV_N - 1);
    end else if (div_step) begin
      rem <= rem_step;
      quo <= quo_step;
      cnt <= cnt - 1'b1;
    end
    if (out_load) begin
      quantized     <= sat;
      position      <= work.pos;
      last_in_block <= (work.pos == jbq_pkg::LAST_POS);
    end
  end

endmodule

// ===== rtl/jpeg_block_quantizer_top.sv =====
// top level of the jpeg block quantizer
//
// input channel (in_valid/in_ready): command selects a table load
// (table_index, table_value) or the quantization of one coefficient.
// loads write the table and give no result. coefficients arrive in
// block order; the block tags each with its position 0..63 and raises
// last_in_block on position 63.
// output channel (out_valid/out_ready): quantized, position, last_in_block.
// cfg_write with cfg_data sets the quality; write it only while idle.
// a coefficient occupies the back end for a pop, the scaling of the table
// entry (multiply, reciprocal, correction), the steps of the shared
// bit-serial divider and a write of the output register. after a quality
// change below 50 the first coefficient also waits while the same divider
// forms 5000/quality. a two-entry queue separates the front from the back,
// so loads and further coefficients are taken while the output register
// is stalled, until the queue and the front stage are full.
// reset (synchronous) clears the position counter, the queue and the
// output valid flag, and sets quality to 50; table contents are undefined
// until loaded.
module jpeg_block_quantizer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [jbq_pkg::QUAL_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [jbq_pkg::POS_W-1:0]         table_index,
  input  logic [jbq_pkg::ENTRY_W-1:0]       table_value,
  input  logic signed [jbq_pkg::COEF_W-1:0] coefficient,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [jbq_pkg::OUT_W-1:0]  quantized,
  output logic [jbq_pkg::POS_W-1:0]         position,
  output logic                              last_in_block
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  jbq_pkg::q_entry_t q_wdata;
  jbq_pkg::q_entry_t q_rdata;

  jbq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .table_index (table_index),
    .table_value (table_value),
    .coefficient (coefficient),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  jbq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  jbq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .quantized     (quantized),
    .position      (position),
    .last_in_block (last_in_block)
  );

endmodule

// ===== rtl/jbq_checker.sv =====
// port-level checker for the block quantizer, bound to the top level
`include "jpeg_block_quantizer_top_defines.svh"

module jbq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [jbq_pkg::OUT_W-1:0] quantized,
  input logic [jbq_pkg::POS_W-1:0]        position,
  input logic                             last_in_block
);

  `JBQ_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result visible after reset")

  `JBQ_ASSERT(a_last_matches_pos, out_valid |-> (last_in_block == (position == jbq_pkg::LAST_POS)), "last flag disagrees with position")

  `JBQ_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(quantized) && $stable(position), "stalled result changed")

  `JBQ_ASSERT(a_drop_only_taken, $fell(out_valid) && !$past(rst) |-> $past(out_ready), "result withdrawn without being taken")

endmodule

bind jpeg_block_quantizer_top jbq_checker u_jbq_checker (.*);
